// ----- rtl/tkvl_pkg.sv -----
// Package for the top-k volume list: record type, mode codes, cell controls.
// Used by tkvl_cell and top_k_volume_list.
`default_nettype none
package tkvl_pkg;

  localparam int DEPTH_DEF = 100;

  localparam int LINK_W   = 31;
  localparam int NODE_W   = 31;
  localparam int PERIOD_W = 8;
  localparam int VOL_W    = 32;
  localparam int MODE_W   = 2;
  localparam int RIDX_W   = 7;
  localparam int COUNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFFER = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef struct packed {
    logic [LINK_W-1:0]   link;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [PERIOD_W-1:0] period;
    logic [VOL_W-1:0]    volume;
  } rec_t;

  typedef struct packed {
    logic offer;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/tkvl_cell.sv -----
// One slot of the sorted list: holds a record and its valid bit, and takes
// the candidate or its upper neighbor's record on an insert. Uses tkvl_pkg.
`default_nettype none
module tkvl_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tkvl_pkg::cell_ctl_t ctl,
  input  wire tkvl_pkg::rec_t    cand,
  input  wire tkvl_pkg::rec_t    prev_rec,
  input  wire logic              prev_valid,
  input  wire logic              prev_ins,
  output tkvl_pkg::rec_t         rec,
  output logic                   valid,
  output logic                   ins
);

  tkvl_pkg::rec_t rec_r, rec_nxt;
  logic           valid_r, valid_nxt;

  assign ins   = !valid_r || (rec_r.volume < cand.volume);
  assign rec   = rec_r;
  assign valid = valid_r;

  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.offer) begin
      if (prev_ins) begin
        rec_nxt   = prev_rec;
        valid_nxt = prev_valid;
      end else if (ins) begin
        rec_nxt   = cand;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/top_k_volume_list.sv -----
// Top level of the top-k volume list: a row of tkvl_cell slots, the held
// count, the minimum volume register and the result register. Uses tkvl_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per command:
//   offer a candidate record, read the entry at in_read_index, or clear.
//   Result channel (out_valid / out_stall) returns exactly one transaction
//   per input transaction, in order.
//   The result is registered at the edge that takes the input.
//   Throughput is one transaction per cycle while in_stall is low; each slot compares
//   the candidate volume with its own record and shifts from its neighbor
//   in the same cycle, so an insert needs no search over the list.
//   While the result register holds an untaken transaction and out_stall
//   is high, in_stall is high and the list holds.
//   cfg_we writes cfg_minimum_volume; write it only while idle.
//   Reset (rst_n low, synchronous) empties the list, zeroes the count and
//   the minimum volume, and drops any pending result.
`default_nettype none
module top_k_volume_list #(
  parameter int DEPTH = tkvl_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tkvl_pkg::VOL_W-1:0]    cfg_minimum_volume,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tkvl_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [tkvl_pkg::RIDX_W-1:0]   in_read_index,
  input  wire logic [tkvl_pkg::LINK_W-1:0]   in_link_id,
  input  wire logic [tkvl_pkg::NODE_W-1:0]   in_from_node,
  input  wire logic [tkvl_pkg::NODE_W-1:0]   in_to_node,
  input  wire logic [tkvl_pkg::PERIOD_W-1:0] in_period,
  input  wire logic [tkvl_pkg::VOL_W-1:0]    in_volume,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_accepted,
  output logic                               out_entry_valid,
  output logic [tkvl_pkg::LINK_W-1:0]        out_link,
  output logic [tkvl_pkg::NODE_W-1:0]        out_from,
  output logic [tkvl_pkg::NODE_W-1:0]        out_to,
  output logic [tkvl_pkg::PERIOD_W-1:0]      out_period,
  output logic [tkvl_pkg::VOL_W-1:0]         out_volume,
  output logic [tkvl_pkg::COUNT_W-1:0]       out_entry_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  tkvl_pkg::rec_t      cand;
  tkvl_pkg::rec_t      cell_rec   [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_ins;
  tkvl_pkg::cell_ctl_t ctl;

  logic [tkvl_pkg::VOL_W-1:0] min_vol_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [31:0]                cnt_ext;
  logic                       in_acc, full, go;
  logic [tkvl_pkg::VOL_W-1:0] thresh;

  logic                          out_valid_r, out_valid_nxt;
  logic                          acc_r, acc_nxt;
  logic                          ev_r, ev_nxt;
  tkvl_pkg::rec_t                rd_r, rd_nxt;
  logic [tkvl_pkg::COUNT_W-1:0]  cnt_out_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign cand.link      = in_link_id;
  assign cand.from_node = in_from_node;
  assign cand.to_node   = in_to_node;
  assign cand.period    = in_period;
  assign cand.volume    = in_volume;

  assign full   = cell_valid[DEPTH-1];
  assign thresh = full ? cell_rec[DEPTH-1].volume : '0;
  assign go     = in_acc && (in_mode == tkvl_pkg::MODE_OFFER) &&
                  (in_volume >= min_vol_r) && (in_volume > thresh);

  assign ctl.offer = go;
  assign ctl.clear = in_acc && (in_mode == tkvl_pkg::MODE_CLEAR);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tkvl_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cand       (cand),
        .prev_rec   ('0),
        .prev_valid (1'b0),
        .prev_ins   (1'b0),
        .rec        (cell_rec[i]),
        .valid      (cell_valid[i]),
        .ins        (cell_ins[i])
      );
    end else begin : g_body
      tkvl_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cand       (cand),
        .prev_rec   (cell_rec[i-1]),
        .prev_valid (cell_valid[i-1]),
        .prev_ins   (cell_ins[i-1]),
        .rec        (cell_rec[i]),
        .valid      (cell_valid[i]),
        .ins        (cell_ins[i])
      );
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      cnt_nxt = '0;
    end else if (go && !full) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign cnt_ext = 32'(cnt_nxt);

  always_comb begin
    acc_nxt = 1'b0;
    ev_nxt  = 1'b0;
    rd_nxt  = '0;
    case (in_mode)
      tkvl_pkg::MODE_OFFER: begin
        acc_nxt = go;
      end
      tkvl_pkg::MODE_READ: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (cell_valid[i] && (32'(in_read_index) == 32'(i))) begin
            ev_nxt = 1'b1;
            rd_nxt = rd_nxt | cell_rec[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_vol_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_vol_r <= cfg_minimum_volume;
      end
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_r     <= acc_nxt;
      ev_r      <= ev_nxt;
      rd_r      <= rd_nxt;
      cnt_out_r <= cnt_ext[tkvl_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = acc_r;
  assign out_entry_valid = ev_r;
  assign out_link        = rd_r.link;
  assign out_from        = rd_r.from_node;
  assign out_to          = rd_r.to_node;
  assign out_period      = rd_r.period;
  assign out_volume      = rd_r.volume;
  assign out_entry_count = cnt_out_r;

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == tkvl_pkg::MODE_CLEAR)) |=> (cnt_r == '0) && !cell_valid[0])
    else $error("list not empty after clear");

  a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    full == (32'(cnt_r) == 32'(DEPTH)))
    else $error("last slot valid disagrees with held count");

  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[0] == (cnt_r != '0))
    else $error("first slot valid disagrees with held count");

  a_offer_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && acc_r) |-> !ev_r && (rd_r == '0))
    else $error("offer result carries read data");

endmodule
`default_nettype wire

// ----- verif/top_k_volume_list_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for top_k_volume_list: a directed stimulus table, then
// random offer/read/clear traffic, checked vs. literals or a shadow sorted list.
// Depends on tkvl_pkg and the top_k_volume_list RTL.
module top_k_volume_list_test;
  import tkvl_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS = 10_000_000;
  localparam rec_t TOP_REC = '1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [RIDX_W-1:0] read_index;
    rec_t              rec;
  } cmd_t;

  typedef struct packed {
    logic               accepted;
    logic               entry_valid;
    rec_t               rec;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_LITERAL,
    ROW_FLOOR
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cmd_t      cmd;
    result_t   want;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [VOL_W-1:0]    cfg_minimum_volume;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [RIDX_W-1:0]   in_read_index;
  logic [LINK_W-1:0]   in_link_id;
  logic [NODE_W-1:0]   in_from_node;
  logic [NODE_W-1:0]   in_to_node;
  logic [PERIOD_W-1:0] in_period;
  logic [VOL_W-1:0]    in_volume;
  logic                out_valid;
  logic                out_stall;
  logic                out_accepted;
  logic                out_entry_valid;
  logic [LINK_W-1:0]   out_link;
  logic [NODE_W-1:0]   out_from;
  logic [NODE_W-1:0]   out_to;
  logic [PERIOD_W-1:0] out_period;
  logic [VOL_W-1:0]    out_volume;
  logic [COUNT_W-1:0]  out_entry_count;

  rec_t             shadow_rec [DEPTH];
  int               shadow_held;
  logic [VOL_W-1:0] floor_vol;
  result_t          pending_results [$];
  row_t             directed_plan [$];
  int               fault_count = 0;
  int               hold_asked = 0;
  bit               tx_idle_en = 1'b0;
  bit               rx_idle_en = 1'b0;

  top_k_volume_list #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_minimum_volume(cfg_minimum_volume),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_read_index     (in_read_index),
    .in_link_id        (in_link_id),
    .in_from_node      (in_from_node),
    .in_to_node        (in_to_node),
    .in_period         (in_period),
    .in_volume         (in_volume),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_entry_valid   (out_entry_valid),
    .out_link          (out_link),
    .out_from          (out_from),
    .out_to            (out_to),
    .out_period        (out_period),
    .out_volume        (out_volume),
    .out_entry_count   (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic result_t step_shadow_list(cmd_t c);
    result_t          r;
    logic [VOL_W-1:0] bar;
    int               pos;
    r = '0;
    case (c.mode)
      MODE_OFFER: begin
        bar = (shadow_held >= DEPTH) ? shadow_rec[DEPTH-1].volume : '0;
        if (c.rec.volume >= floor_vol && c.rec.volume > bar) begin
          pos = 0;
          while (pos < shadow_held && shadow_rec[pos].volume >= c.rec.volume) pos++;
          if (pos < DEPTH) begin
            for (int i = (shadow_held < DEPTH) ? shadow_held : DEPTH - 1; i > pos; i--) begin
              shadow_rec[i] = shadow_rec[i-1];
            end
            shadow_rec[pos] = c.rec;
            if (shadow_held < DEPTH) shadow_held++;
            r.accepted = 1'b1;
          end
        end
      end
      MODE_READ: begin
        if (int'(c.read_index) < shadow_held) begin
          r.entry_valid = 1'b1;
          r.rec = shadow_rec[c.read_index];
        end
      end
      MODE_CLEAR: begin
        shadow_rec = '{default: '0};
        shadow_held = 0;
      end
      default: ;
    endcase
    r.count = COUNT_W'(shadow_held);
    return r;
  endfunction

  function automatic result_t lit(logic acc, logic hit, rec_t r, int cnt);
    result_t w;
    w.accepted = acc;
    w.entry_valid = hit;
    w.rec = r;
    w.count = COUNT_W'(cnt);
    return w;
  endfunction

  function automatic rec_t rec_of(logic [LINK_W-1:0] l, logic [NODE_W-1:0] f,
                                  logic [NODE_W-1:0] t, logic [PERIOD_W-1:0] p,
                                  logic [VOL_W-1:0] v);
    rec_t r;
    r.link = l;
    r.from_node = f;
    r.to_node = t;
    r.period = p;
    r.volume = v;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("acc=%0d hit=%0d link=%h from=%h to=%h per=%h vol=%h cnt=%0d",
                     r.accepted, r.entry_valid, r.rec.link, r.rec.from_node,
                     r.rec.to_node, r.rec.period, r.rec.volume, r.count);
  endfunction

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      1: return floor_vol - 32'd1 + VOL_W'($urandom_range(0, 2));
      2, 3: begin
        if (shadow_held == 0) return VOL_W'($urandom());
        return shadow_rec[shadow_held-1].volume - 32'd1 + VOL_W'($urandom_range(0, 2));
      end
      4, 5: return VOL_W'($urandom_range(0, 63));
      default: return VOL_W'($urandom());
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 999);
    if (pick < 3) c.mode = MODE_CLEAR;
    else if (pick < 25) c.mode = MODE_SPARE;
    else if (pick < 260) c.mode = MODE_READ;
    else c.mode = MODE_OFFER;
    case ($urandom_range(0, 9))
      0: c.read_index = RIDX_W'(DEPTH - 1 + $urandom_range(0, 1));
      1: c.read_index = RIDX_W'($urandom());
      2: c.read_index = RIDX_W'((shadow_held == 0) ? 0 : shadow_held - 1);
      default: c.read_index = RIDX_W'($urandom_range(0, shadow_held));
    endcase
    c.rec.link = LINK_W'($urandom());
    c.rec.from_node = NODE_W'($urandom());
    c.rec.to_node = NODE_W'($urandom());
    c.rec.period = PERIOD_W'($urandom_range(0, 255));
    c.rec.volume = pick_volume();
    return c;
  endfunction

  task automatic plan_row(row_kind_t k, logic [MODE_W-1:0] m, logic [RIDX_W-1:0] idx,
                          rec_t r, result_t w = '0);
    row_t row;
    row.kind = k;
    row.cmd.mode = m;
    row.cmd.read_index = idx;
    row.cmd.rec = r;
    row.want = w;
    directed_plan.push_back(row);
  endtask

  task automatic send_cmd(cmd_t c, bit literal, result_t want);
    int      gap;
    result_t res;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= c.mode;
    in_read_index <= c.read_index;
    in_link_id    <= c.rec.link;
    in_from_node  <= c.rec.from_node;
    in_to_node    <= c.rec.to_node;
    in_period     <= c.rec.period;
    in_volume     <= c.rec.volume;
    do @(posedge clk); while (in_stall);
    res = step_shadow_list(c);
    pending_results.push_back(literal ? want : res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_floor(logic [VOL_W-1:0] v);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we             <= 1'b1;
    cfg_minimum_volume <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    floor_vol = v;
  endtask

  task automatic note_fault(string what, result_t want, result_t got);
    fault_count++;
    if (fault_count <= 10) $display("%s: want %s / got %s", what, show(want), show(got));
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.accepted = out_accepted;
      got.entry_valid = out_entry_valid;
      got.rec.link = out_link;
      got.rec.from_node = out_from;
      got.rec.to_node = out_to;
      got.rec.period = out_period;
      got.rec.volume = out_volume;
      got.count = out_entry_count;
      if (pending_results.size() == 0) begin
        note_fault("transaction with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted || got.entry_valid !== want.entry_valid ||
            got.rec.link !== want.rec.link || got.rec.from_node !== want.rec.from_node ||
            got.rec.to_node !== want.rec.to_node || got.rec.period !== want.rec.period ||
            got.rec.volume !== want.rec.volume || got.count !== want.count) begin
          note_fault("mismatch", want, got);
        end
      end
    end
  end

  initial begin : rx_pacing
    int served;
    served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    cmd_t             c;
    logic [VOL_W-1:0] phase_floor;
    int               phase_len;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_minimum_volume <= '0;
    in_valid           <= 1'b0;
    in_mode            <= MODE_OFFER;
    in_read_index      <= '0;
    in_link_id         <= '0;
    in_from_node       <= '0;
    in_to_node         <= '0;
    in_period          <= '0;
    in_volume          <= '0;
    shadow_rec = '{default: '0};
    shadow_held = 0;
    floor_vol = '0;

    plan_row(ROW_LITERAL, MODE_READ, 0, '0, lit(0, 0, '0, 0));
    plan_row(ROW_LITERAL, MODE_SPARE, '1, TOP_REC, lit(0, 0, '0, 0));
    plan_row(ROW_LITERAL, MODE_OFFER, 0, rec_of('1, '1, '1, '1, '0), lit(0, 0, '0, 0));
    plan_row(ROW_LITERAL, MODE_OFFER, 0, TOP_REC, lit(1, 0, '0, 1));
    plan_row(ROW_LITERAL, MODE_READ, 0, '0, lit(0, 1, TOP_REC, 1));
    plan_row(ROW_LITERAL, MODE_READ, '1, '0, lit(0, 0, '0, 1));
    plan_row(ROW_LITERAL, MODE_READ, 1, '0, lit(0, 0, '0, 1));
    plan_row(ROW_LITERAL, MODE_OFFER, 0, rec_of('0, '0, '0, '0, 32'd1), lit(1, 0, '0, 2));
    plan_row(ROW_PREDICT, MODE_OFFER, 0,
             rec_of(31'h2AAA_AAAA, 31'h5555_5555, 31'h1234_5678, 8'hA5, 32'd1));
    plan_row(ROW_PREDICT, MODE_READ, 1, '0);
    plan_row(ROW_PREDICT, MODE_READ, 2, '0);
    plan_row(ROW_PREDICT, MODE_OFFER, 0,
             rec_of(31'h0F0F_0F0F, 31'h7070_7070, 31'h0000_0001, 8'h5A, 32'h8000_0000));
    plan_row(ROW_PREDICT, MODE_READ, 0, '0);
    plan_row(ROW_PREDICT, MODE_READ, 1, '0);
    plan_row(ROW_PREDICT, MODE_SPARE, 1, rec_of(31'h1, 31'h2, 31'h3, 8'h4, 32'h5));
    plan_row(ROW_LITERAL, MODE_CLEAR, 0, TOP_REC, lit(0, 0, '0, 0));
    plan_row(ROW_LITERAL, MODE_READ, 0, '0, lit(0, 0, '0, 0));
    plan_row(ROW_FLOOR, MODE_OFFER, 0, rec_of('0, '0, '0, '0, '1));
    plan_row(ROW_LITERAL, MODE_OFFER, 0, rec_of('1, '0, '1, '0, 32'hFFFF_FFFE),
             lit(0, 0, '0, 0));
    plan_row(ROW_LITERAL, MODE_OFFER, 0, TOP_REC, lit(1, 0, '0, 1));
    plan_row(ROW_LITERAL, MODE_OFFER, 0, TOP_REC, lit(1, 0, '0, 2));
    plan_row(ROW_PREDICT, MODE_READ, 1, '0);
    plan_row(ROW_FLOOR, MODE_OFFER, 0, rec_of('0, '0, '0, '0, 32'd16));
    plan_row(ROW_LITERAL, MODE_OFFER, 0, rec_of(31'd1, 31'd2, 31'd3, 8'd4, 32'd15),
             lit(0, 0, '0, 2));
    plan_row(ROW_PREDICT, MODE_OFFER, 0, rec_of(31'd7, 31'd8, 31'd9, 8'd10, 32'd16));
    plan_row(ROW_LITERAL, MODE_CLEAR, 0, '0, lit(0, 0, '0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_FLOOR) begin
        set_floor(directed_plan[i].cmd.rec.volume);
      end else begin
        send_cmd(directed_plan[i].cmd, directed_plan[i].kind == ROW_LITERAL,
                 directed_plan[i].want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: phase_floor = VOL_W'($urandom_range(1, 512));
        2: phase_floor = '1;
        4: phase_floor = VOL_W'($urandom());
        default: phase_floor = '0;
      endcase
      phase_len = (ph == 2) ? 150 : 330;
      tx_idle_en = (ph != 0 && ph != 5);
      rx_idle_en <= (ph != 1 && ph != 5);
      set_floor(phase_floor);
      if (ph >= 2) begin
        c = rand_cmd();
        c.mode = MODE_CLEAR;
        send_cmd(c, 1'b0, '0);
      end
      for (int n = 0; n < phase_len; n++) begin
        // hold the result side while commands keep coming
        if (ph == 2 && n == 100) hold_asked <= hold_asked + 1;
        if (n == phase_len / 2) wait_drained();
        send_cmd(rand_cmd(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tkvl_pkg.sv
rtl/tkvl_cell.sv
rtl/top_k_volume_list.sv
verif/top_k_volume_list_test.sv
